// ===== rtl/range_residual_jacobian_macros.svh =====
// Assertion macros used by the checker file.
`ifndef RANGE_RESIDUAL_JACOBIAN_MACROS_SVH
`define RANGE_RESIDUAL_JACOBIAN_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define RRJ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define RRJ_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/rrj_pkg.sv =====
// ----------------------------------------------------------------------------
// rrj_pkg
// Widths, latency and types of the range residual and gradient pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rrj_pkg;

	localparam int CW   = 32;             // coordinate width, Q.16
	localparam int DW   = CW + 1;         // coordinate difference width
	localparam int MW   = CW - 1;         // measured range width used
	localparam int SW   = 2 * DW;         // sum of squares width
	localparam int QW   = DW;             // square root width
	localparam int RMW  = QW + 1;         // square root remainder width
	localparam int LW   = QW + 1;         // rounded distance width
	localparam int FRAC = 16;
	localparam int FB   = 24;             // gradient fraction bits
	localparam int QB   = FB + 1;         // quotient bits, |grad| <= 1.0
	localparam int VW   = SW + 1;         // squared residual before scaling
	localparam int GW   = 48;
	localparam int OW   = 64;
	localparam int SQS  = 9;              // 2*d in Q.24
	localparam int SQG  = DW + SQS;
	localparam int MXA  = (SQG > QB + 1) ? SQG : QB + 1;
	localparam int MXW  = (MXA > GW + 1) ? MXA : GW + 1;
	localparam int TW   = VW - FRAC;
	localparam int XW   = (TW > OW) ? TW : OW;

	// three front stages, one per root bit, rounding, one per quotient bit,
	// gradient and output register
	localparam int LAT  = QW + QB + 5;

	localparam logic [1:0] CFG_TWO_D   = 2'd0;
	localparam logic [1:0] CFG_SQUARED = 2'd1;

	typedef struct packed {
		logic                 last;
		logic [2:0]           neg;
		logic [2:0][DW-1:0]   mag;
		logic [MW-1:0]        r;
		logic [VW-1:0]        v;
	} side_t;

endpackage

`default_nettype wire

// ===== rtl/range_residual_jacobian.sv =====
// ----------------------------------------------------------------------------
// range_residual_jacobian
// Range residual and gradient row for multilateration, fully pipelined.
// ----------------------------------------------------------------------------
// One word is taken per clock whenever start is high; busy stays low. Each
// result appears with done after the front, root, rounding, divider and
// output stages, one per cycle, in order. The square root settles one root
// bit per stage (33 stages), the divider one quotient bit per stage (25
// stages, all three axes in parallel). Results cannot be
// held off. Write the mode registers only while no word is in flight.
`default_nettype none

module range_residual_jacobian (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] anchor_x,
	input  logic signed [31:0] anchor_y,
	input  logic signed [31:0] anchor_z,
	input  logic [30:0]        measured_range,
	input  logic               last_measure,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic               cfg_data,
	output logic               done,
	output logic signed [63:0] residual,
	output logic signed [47:0] grad_x,
	output logic signed [47:0] grad_y,
	output logic signed [47:0] grad_z,
	output logic               zero_range,
	output logic               last_result
);

	localparam int DW  = rrj_pkg::DW;
	localparam int MW  = rrj_pkg::MW;
	localparam int SW  = rrj_pkg::SW;
	localparam int QW  = rrj_pkg::QW;
	localparam int RMW = rrj_pkg::RMW;
	localparam int LW  = rrj_pkg::LW;
	localparam int QB  = rrj_pkg::QB;
	localparam int VW  = rrj_pkg::VW;
	localparam int GW  = rrj_pkg::GW;
	localparam int OW  = rrj_pkg::OW;
	localparam int MXW = rrj_pkg::MXW;
	localparam int XW  = rrj_pkg::XW;
	localparam int CW  = rrj_pkg::CW;

	localparam logic signed [OW-1:0] RES_MAX = {1'b0, {(OW-1){1'b1}}};
	localparam logic signed [OW-1:0] RES_MIN = {1'b1, {(OW-1){1'b0}}};

	function automatic logic [GW-1:0] sat_grad(input logic neg, input logic [MXW-1:0] m);
		logic [MXW-1:0] lim;
		logic [MXW-1:0] mm;
		begin
			lim = neg ? (MXW'(1) << (GW-1)) : ((MXW'(1) << (GW-1)) - MXW'(1));
			mm  = (m > lim) ? lim : m;
			return neg ? GW'(-mm) : GW'(mm);
		end
	endfunction

	function automatic logic [OW-1:0] sat_res(input logic [VW-1:0] v);
		logic signed [XW-1:0] x;
		begin
			x = XW'($signed(v[VW-1:rrj_pkg::FRAC]));
			if (x > RES_MAX)
				return RES_MAX;
			else if (x < RES_MIN)
				return RES_MIN;
			else
				return OW'(x);
		end
	endfunction

	// mode registers
	logic two_d_q, squared_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			two_d_q   <= 1'b0;
			squared_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rrj_pkg::CFG_TWO_D:   two_d_q   <= cfg_data;
				rrj_pkg::CFG_SQUARED: squared_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: differences
	logic [2:0][CW-1:0] pc, ac;
	logic [2:0][DW-1:0] dif;

	assign pc[0] = CW'(pos_x);
	assign pc[1] = CW'(pos_y);
	assign pc[2] = CW'(pos_z);
	assign ac[0] = CW'(anchor_x);
	assign ac[1] = CW'(anchor_y);
	assign ac[2] = CW'(anchor_z);

	always_comb begin
		for (int k = 0; k < 3; k++)
			dif[k] = {pc[k][CW-1], pc[k]} - {ac[k][CW-1], ac[k]};
	end

	logic           vld_s1, vld_s2, vld_s3;
	rrj_pkg::side_t side_s1, side_s2, side_s3;
	logic [2:0][SW-1:0] sq_s2;
	logic [SW-1:0]  rr_s2;
	logic [SW-1:0]  sum_s3;
	logic [SW-1:0]  sum_c;

	assign sum_c = sq_s2[0] + sq_s2[1] + sq_s2[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		side_s1.last <= last_measure;
		side_s1.r    <= MW'(measured_range);
		side_s1.v    <= '0;
		for (int k = 0; k < 3; k++) begin
			side_s1.neg[k] <= dif[k][DW-1];
			side_s1.mag[k] <= dif[k][DW-1] ? DW'(-dif[k]) : dif[k];
		end
		// stage 2: squares
		side_s2 <= side_s1;
		for (int k = 0; k < 3; k++)
			sq_s2[k] <= SW'(side_s1.mag[k]) * SW'(side_s1.mag[k]);
		rr_s2 <= SW'(side_s1.r) * SW'(side_s1.r);
		// stage 3: sum and squared residual before scaling
		side_s3.last <= side_s2.last;
		side_s3.neg  <= side_s2.neg;
		side_s3.mag  <= side_s2.mag;
		side_s3.r    <= side_s2.r;
		side_s3.v    <= VW'(sum_c) - VW'(rr_s2) + (VW'(1) << (rrj_pkg::FRAC - 1));
		sum_s3       <= sum_c;
	end

	// square root, one root bit per stage
	logic [QW-1:0]  rt_vld_s;
	logic [RMW-1:0] rt_rem_s  [QW];
	logic [QW-1:0]  rt_root_s [QW];
	logic [SW-1:0]  rt_sum_s  [QW];
	rrj_pkg::side_t rt_side_s [QW];

	logic [QW-1:0]  rin_vld;
	logic [RMW-1:0] rin_rem  [QW];
	logic [QW-1:0]  rin_root [QW];
	logic [SW-1:0]  rin_sum  [QW];
	rrj_pkg::side_t rin_side [QW];
	logic [QW+2:0]  rt_cur   [QW];
	logic [QW+2:0]  rt_trial [QW];
	logic [QW-1:0]  rt_take;

	always_comb begin
		rin_vld[0]  = vld_s3;
		rin_rem[0]  = '0;
		rin_root[0] = '0;
		rin_sum[0]  = sum_s3;
		rin_side[0] = side_s3;
		for (int i = 1; i < QW; i++) begin
			rin_vld[i]  = rt_vld_s[i-1];
			rin_rem[i]  = rt_rem_s[i-1];
			rin_root[i] = rt_root_s[i-1];
			rin_sum[i]  = rt_sum_s[i-1];
			rin_side[i] = rt_side_s[i-1];
		end
		for (int i = 0; i < QW; i++) begin
			rt_cur[i]   = {rin_rem[i], rin_sum[i][SW-1-2*i -: 2]};
			rt_trial[i] = {1'b0, rin_root[i], 2'b01};
			rt_take[i]  = rt_cur[i] >= rt_trial[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rt_vld_s <= '0;
		else
			rt_vld_s <= rin_vld;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < QW; i++) begin
			rt_rem_s[i]  <= rt_take[i] ? RMW'(rt_cur[i] - rt_trial[i]) : RMW'(rt_cur[i]);
			rt_root_s[i] <= {rin_root[i][QW-2:0], rt_take[i]};
			rt_sum_s[i]  <= rin_sum[i];
			rt_side_s[i] <= rin_side[i];
		end
	end

	// stage 4: round the root, form the residual
	logic [LW-1:0]  dist_c;
	logic           vld_s4;
	rrj_pkg::side_t side_s4;
	logic [LW-1:0]  dist_s4;
	logic [OW-1:0]  resid_s4;
	logic           zero_s4;

	assign dist_c = LW'(rt_root_s[QW-1]) + LW'(rt_rem_s[QW-1] > RMW'(rt_root_s[QW-1]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s4 <= 1'b0;
		else
			vld_s4 <= rt_vld_s[QW-1];
	end

	always_ff @(posedge clk) begin
		side_s4  <= rt_side_s[QW-1];
		dist_s4  <= dist_c;
		resid_s4 <= squared_q ? sat_res(rt_side_s[QW-1].v)
		                      : OW'(dist_c) - OW'(rt_side_s[QW-1].r);
		zero_s4  <= !squared_q && (dist_c == '0);
	end

	// divider: |d| * 2^24 / dist, one quotient bit per stage per axis
	logic [QB-1:0]          dv_vld_s;
	logic [2:0][QB-1:0]     dv_q_s    [QB];
	logic [2:0][LW-1:0]     dv_rem_s  [QB];
	logic [LW-1:0]          dv_dist_s [QB];
	logic [OW-1:0]          dv_res_s  [QB];
	logic [QB-1:0]          dv_zero_s;
	rrj_pkg::side_t         dv_side_s [QB];

	logic [QB-1:0]          din_vld;
	logic [2:0][QB-1:0]     din_q    [QB];
	logic [2:0][LW-1:0]     din_rem  [QB];
	logic [LW-1:0]          din_dist [QB];
	logic [OW-1:0]          din_res  [QB];
	logic [QB-1:0]          din_zero;
	rrj_pkg::side_t         din_side [QB];
	logic [2:0][LW:0]       dv_cur   [QB];
	logic [2:0]             dv_take  [QB];

	always_comb begin
		din_vld[0]  = vld_s4;
		din_dist[0] = dist_s4;
		din_res[0]  = resid_s4;
		din_zero[0] = zero_s4;
		din_side[0] = side_s4;
		for (int k = 0; k < 3; k++) begin
			din_q[0][k]   = '0;
			// top quotient bits are zero, so start from the upper numerator bits
			din_rem[0][k] = LW'(side_s4.mag[k] >> 1);
		end
		for (int j = 1; j < QB; j++) begin
			din_vld[j]  = dv_vld_s[j-1];
			din_q[j]    = dv_q_s[j-1];
			din_rem[j]  = dv_rem_s[j-1];
			din_dist[j] = dv_dist_s[j-1];
			din_res[j]  = dv_res_s[j-1];
			din_zero[j] = dv_zero_s[j-1];
			din_side[j] = dv_side_s[j-1];
		end
		for (int j = 0; j < QB; j++) begin
			for (int k = 0; k < 3; k++) begin
				dv_cur[j][k]  = {din_rem[j][k], (j == 0) ? din_side[j].mag[k][0] : 1'b0};
				dv_take[j][k] = dv_cur[j][k] >= {1'b0, din_dist[j]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dv_vld_s <= '0;
		else
			dv_vld_s <= din_vld;
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < QB; j++) begin
			for (int k = 0; k < 3; k++) begin
				dv_rem_s[j][k] <= dv_take[j][k] ? LW'(dv_cur[j][k] - {1'b0, din_dist[j]})
				                                : LW'(dv_cur[j][k]);
				dv_q_s[j][k]   <= {din_q[j][k][QB-2:0], dv_take[j][k]};
			end
			dv_dist_s[j] <= din_dist[j];
			dv_res_s[j]  <= din_res[j];
			dv_zero_s[j] <= din_zero[j];
			dv_side_s[j] <= din_side[j];
		end
	end

	// gradient: round quotient or take 2*d, saturate; clear at zero range, z in 2-D
	rrj_pkg::side_t       fs;
	logic [2:0][MXW-1:0]  gm;
	logic [2:0][GW-1:0]   gv;
	logic                 rnd;

	assign fs = dv_side_s[QB-1];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			rnd = {dv_rem_s[QB-1][k], 1'b0} >= {1'b0, dv_dist_s[QB-1]};
			gm[k] = squared_q ? (MXW'(fs.mag[k]) << rrj_pkg::SQS)
			                  : MXW'(dv_q_s[QB-1][k]) + MXW'(rnd);
			gv[k] = dv_zero_s[QB-1] ? '0 : sat_grad(fs.neg[k], gm[k]);
		end
		if (two_d_q)
			gv[2] = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done <= 1'b0;
		else
			done <= dv_vld_s[QB-1];
	end

	always_ff @(posedge clk) begin
		residual    <= dv_res_s[QB-1];
		grad_x      <= gv[0];
		grad_y      <= gv[1];
		grad_z      <= gv[2];
		zero_range  <= dv_zero_s[QB-1];
		last_result <= fs.last;
	end

endmodule

`default_nettype wire

// ===== rtl/rrj_checker.sv =====
// ----------------------------------------------------------------------------
// rrj_checker
// Port-level checks on the range residual pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "range_residual_jacobian_macros.svh"

module rrj_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic               last_measure,
	input  logic               done,
	input  logic signed [63:0] residual,
	input  logic signed [47:0] grad_x,
	input  logic signed [47:0] grad_y,
	input  logic signed [47:0] grad_z,
	input  logic               zero_range,
	input  logic               last_result
);

	// every result word comes from a word taken earlier through the pipeline
	`RRJ_ASSERT(a_latency, clk, arst_n, done |-> $past(start && !busy, rrj_pkg::LAT), "result without matching start")
	`RRJ_ASSERT(a_last_tag, clk, arst_n, done |-> (last_result == $past(last_measure, rrj_pkg::LAT)), "batch end tag out of step")
	`RRJ_ASSERT(a_zero_grad, clk, arst_n, (done && zero_range) |-> (grad_x == 0 && grad_y == 0 && grad_z == 0), "nonzero gradient at zero distance")
	`RRJ_NEVER(a_zero_res, clk, arst_n, done && zero_range && (residual > 0), "positive residual at zero distance")

endmodule

bind range_residual_jacobian rrj_checker u_rrj_checker (.*);

`default_nettype wire
